// ----- rtl/ntst_pkg.sv -----
// Package for the number-to-speech token sequencer: token codes, slot layout,
// stage payload types and the decimal place helper functions. No dependencies.
package ntst_pkg;

  localparam logic [7:0]  TrackMinus = 8'd250;
  localparam logic [7:0]  TrackZero  = 8'd200;
  localparam logic [13:0] DirectMax  = 14'd19;
  localparam logic signed [14:0] NumLimit = 15'sd9999;

  localparam logic [13:0] Weight3 = 14'd1000;
  localparam logic [13:0] Weight2 = 14'd100;
  localparam logic [13:0] Weight1 = 14'd10;

  // Token slots of one item, in speaking order.
  localparam int NumSlots = 7;
  localparam int SlotPfx  = 0;
  localparam int SlotSign = 1;
  localparam int SlotP3   = 2;
  localparam int SlotP2   = 3;
  localparam int SlotP1   = 4;
  localparam int SlotP0   = 5;
  localparam int SlotSfx  = 6;

  // Tracks that every stage carries unchanged once the front stage has set them.
  typedef struct packed {
    logic       pfx_v;
    logic [7:0] pfx;
    logic       sgn_v;
    logic [7:0] sgn_tok;
    logic       sfx_v;
    logic [7:0] sfx;
  } head_t;

  typedef struct packed {
    logic [3:0]  digit;
    logic [13:0] rem;
  } place_t;

  // One decimal place: digit by parallel compares, then the remainder.
  function automatic place_t place_step(input logic [13:0] rem, input logic [13:0] w);
    place_t r;
    logic [3:0] d;
    d = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem >= 14'(k) * w) d = 4'(k);
    end
    r.digit = d;
    r.rem   = rem - 14'(d) * w;
    return r;
  endfunction

  // Track for a place: tens code plus digit above the direct range, else the value itself.
  function automatic logic [7:0] place_token(input logic [13:0] rem, input logic [3:0] digit,
                                             input logic [3:0] tens);
    if (rem > DirectMax) return 8'(tens) * 8'd10 + 8'(digit);
    else return rem[7:0];
  endfunction

  // A place speaks if nonzero, unless an earlier place spoke the remainder directly.
  function automatic logic place_valid(input logic [13:0] rem, input logic [3:0] digit,
                                       input logic done);
    if (done) return 1'b0;
    else if (rem > DirectMax) return digit != 4'd0;
    else return rem != 14'd0;
  endfunction

endpackage

// ----- rtl/number_to_speech_tokens.sv -----
// Number-to-speech token sequencer, top level.
// An item passes each intake stage, then the serialiser, to the registered outputs.
// Throughput: one track per cycle while an item is in hand; the intake keeps
// taking items while the serialiser is busy, until its stages are full.
// Reset (rst, synchronous) clears every valid bit, the token mask and strobe.
// The receiver cannot stall: each track is on the ports for exactly one cycle.
module number_to_speech_tokens
  import ntst_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               has_prefix,
  input  logic [7:0]         prefix_track,
  input  logic signed [14:0] number,
  input  logic               has_suffix,
  input  logic [7:0]         suffix_track,
  output logic               strobe,
  output logic [7:0]         track,
  output logic               last
);

  // Stage 1 registers: saturated magnitude and the fixed head tracks.
  logic        v1;
  head_t       head1;
  logic [13:0] mag1;

  // Stage 2: thousands place done; remainder below 1000.
  logic        v2;
  head_t       head2;
  logic [9:0]  rem2;
  logic        done2;
  logic [7:0]  tok_p3_2;
  logic        val_p3_2;

  // Stage 3: hundreds place done; remainder below 100.
  logic        v3;
  head_t       head3;
  logic [6:0]  rem3;
  logic        done3;
  logic [7:0]  tok_p3_3, tok_p2_3;
  logic        val_p3_3, val_p2_3;

  // Stage 4: the complete token list of the item, one slot per possible track.
  logic        v4;
  logic [7:0]  list_tok [NumSlots];
  logic [NumSlots-1:0] list_mask;

  // Serialiser: tokens still to speak for the item in hand.
  logic [7:0]  ser_tok [NumSlots];
  logic [NumSlots-1:0] ser_mask;

  logic ready1, ready2, ready3, ready4, ser_ready;

  // Handshake chain: a stage moves when it is empty or the next one moves.
  logic [NumSlots-1:0] ser_pick, ser_rest;
  assign ser_pick  = ser_mask & (~ser_mask + NumSlots'(1));
  assign ser_rest  = ser_mask & ~ser_pick;
  assign ser_ready = (ser_rest == '0);
  assign ready4    = !v4 || ser_ready;
  assign ready3    = !v3 || ready4;
  assign ready2    = !v2 || ready3;
  assign ready1    = !v1 || ready2;
  assign busy      = !ready1;

  // Front stage: clamp to the spoken range and split into sign and magnitude.
  logic signed [14:0] num_sat;
  logic               num_neg;
  head_t              head_in;
  always_comb begin
    if (number > NumLimit) num_sat = NumLimit;
    else if (number < -NumLimit) num_sat = -NumLimit;
    else num_sat = number;
    num_neg         = num_sat[14];
    head_in.pfx_v   = has_prefix;
    head_in.pfx     = prefix_track;
    head_in.sfx_v   = has_suffix;
    head_in.sfx     = suffix_track;
    head_in.sgn_v   = num_neg || (num_sat == '0);
    head_in.sgn_tok = num_neg ? TrackMinus : TrackZero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= start;
    end
    if (ready1) begin
      head1 <= head_in;
      mag1  <= num_neg ? 14'(-num_sat) : num_sat[13:0];
    end
  end

  // Thousands place.
  place_t pl3;
  assign pl3 = place_step(mag1, Weight3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
    if (ready2) begin
      head2    <= head1;
      rem2     <= pl3.rem[9:0];
      done2    <= (mag1 <= DirectMax);
      tok_p3_2 <= place_token(mag1, pl3.digit, 4'd4);
      val_p3_2 <= place_valid(mag1, pl3.digit, 1'b0);
    end
  end

  // Hundreds place.
  place_t pl2;
  logic [13:0] rem2_x;
  assign rem2_x = 14'(rem2);
  assign pl2    = place_step(rem2_x, Weight2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= v2;
    end
    if (ready3) begin
      head3    <= head2;
      rem3     <= pl2.rem[6:0];
      done3    <= done2 || (rem2_x <= DirectMax);
      tok_p3_3 <= tok_p3_2;
      val_p3_3 <= val_p3_2;
      tok_p2_3 <= place_token(rem2_x, pl2.digit, 4'd3);
      val_p2_3 <= place_valid(rem2_x, pl2.digit, done2);
    end
  end

  // Tens and units: the units remainder below ten is only ever spoken directly.
  place_t pl1;
  logic [13:0] rem3_x;
  logic        done1;
  assign rem3_x = 14'(rem3);
  assign pl1    = place_step(rem3_x, Weight1);
  assign done1  = done3 || (rem3_x <= DirectMax);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (ready4) begin
      v4 <= v3;
    end
    if (ready4) begin
      list_tok[SlotPfx]   <= head3.pfx;
      list_tok[SlotSign]  <= head3.sgn_tok;
      list_tok[SlotP3]    <= tok_p3_3;
      list_tok[SlotP2]    <= tok_p2_3;
      list_tok[SlotP1]    <= place_token(rem3_x, pl1.digit, 4'd2);
      list_tok[SlotP0]    <= pl1.rem[7:0];
      list_tok[SlotSfx]   <= head3.sfx;
      list_mask[SlotPfx]  <= head3.pfx_v;
      list_mask[SlotSign] <= head3.sgn_v;
      list_mask[SlotP3]   <= val_p3_3;
      list_mask[SlotP2]   <= val_p2_3;
      list_mask[SlotP1]   <= place_valid(rem3_x, pl1.digit, done3);
      list_mask[SlotP0]   <= !done1 && (pl1.rem != 14'd0);
      list_mask[SlotSfx]  <= head3.sfx_v;
    end
  end

  // Serialiser: speak the lowest pending slot each cycle; reload as the last one goes.
  logic [7:0] ser_sel;
  always_comb begin
    ser_sel = '0;
    for (int i = 0; i < NumSlots; i++) begin
      if (ser_pick[i]) ser_sel = ser_sel | ser_tok[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_mask <= '0;
      strobe   <= 1'b0;
    end else begin
      if (ser_ready) ser_mask <= v4 ? list_mask : '0;
      else ser_mask <= ser_rest;
      strobe <= (ser_mask != '0);
    end
    if (ser_ready && v4) begin
      ser_tok <= list_tok;
    end
    track <= ser_sel;
    last  <= ser_ready;
  end

  // Tracks of one item leave on consecutive cycles, ending with a marked one.
  a_item_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("item tracks not contiguous");

  // An empty serialiser lets every stage move, so the intake cannot be busy.
  a_idle_not_busy: assert property (@(posedge clk) disable iff (rst)
    (ser_mask == '0) |-> !busy)
    else $error("busy while serialiser empty");

  // Exactly one slot is chosen while tokens are pending.
  a_one_pick: assert property (@(posedge clk) disable iff (rst)
    (ser_mask != '0) |-> $onehot(ser_pick))
    else $error("serialiser picked more or fewer than one slot");

  // Every loaded item carries at least one token.
  a_list_nonempty: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (list_mask != '0))
    else $error("empty token list");

endmodule
